// ----- hw/rtl/kmf_pkg.sv -----
`default_nettype none

package kmf_pkg;

  localparam int NumWords   = 16;
  localparam int MaxWordLen = 16;
  localparam int WordIdxW   = $clog2(NumWords);
  localparam int CharIdxW   = $clog2(MaxWordLen);
  localparam int LenW       = $clog2(MaxWordLen + 1);
  localparam int FillW      = $clog2(MaxWordLen + 1);
  localparam int ActiveW    = 5;

  localparam logic [7:0] MaskChar = 8'd42;

  localparam logic [1:0] ReqData   = 2'd0;
  localparam logic [1:0] ReqWrByte = 2'd1;
  localparam logic [1:0] ReqSetLen = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] word_slot;
    logic [3:0] char_slot;
    logic [7:0] byte_value;
    logic [4:0] word_length;
    logic       mask_enable;
    logic       last_in;
  } kmf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_masked;
    logic       out_last;
  } kmf_out_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } kmf_win_ent_t;

  typedef kmf_win_ent_t [MaxWordLen-1:0] kmf_win_t;

  typedef struct packed {
    logic       wr_byte;
    logic       wr_len;
    logic [3:0] word_slot;
    logic [3:0] char_slot;
    logic [7:0] byte_value;
    logic [4:0] word_length;
  } kmf_tbl_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kmf_table.sv -----
`default_nettype none

module kmf_table import kmf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kmf_tbl_wr_t         wr_i,
  input  wire logic [WordIdxW-1:0] word_idx_i,
  input  wire kmf_win_t            win_i,
  input  wire logic [FillW-1:0]    fill_i,
  output logic                     hit_o,
  output logic [LenW-1:0]          len_o
);

  logic [MaxWordLen-1:0][7:0] kw_q [NumWords];
  logic [MaxWordLen-1:0][7:0] kw_rd_q;
  logic [LenW-1:0]            len_q [NumWords];
  logic [LenW-1:0]            len_rd_q;
  logic [LenW-1:0]            sat_len;

  assign sat_len = (LenW'(wr_i.word_length) > LenW'(MaxWordLen)) ? LenW'(MaxWordLen)
                                                                 : LenW'(wr_i.word_length);

  // The entry addressed by word_idx_i is compared in the following cycle.
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_byte) begin
      kw_q[WordIdxW'(wr_i.word_slot)][CharIdxW'(wr_i.char_slot)] <= wr_i.byte_value;
    end
    kw_rd_q <= kw_q[word_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumWords; j++) begin
        len_q[j] <= '0;
      end
      len_rd_q <= '0;
    end else begin
      if (wr_i.wr_len) begin
        len_q[WordIdxW'(wr_i.word_slot)] <= sat_len;
      end
      len_rd_q <= len_q[word_idx_i];
    end
  end

  // A keyword hits only when all of its bytes are held and enabled.
  always_comb begin
    len_o = len_rd_q;
    hit_o = (len_o != '0) && (FillW'(len_o) <= fill_i);
    for (int i = 0; i < MaxWordLen; i++) begin
      if (LenW'(i) < len_o) begin
        if (!win_i[i].en || (win_i[i].data != kw_rd_q[i])) begin
          hit_o = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/keyword_mask_filter_core.sv -----
// Streaming keyword masker.
// Requests enter on the in channel (in_valid_i, in_stall_o, in_req_i). A table
// request writes one keyword byte or one keyword length and is done in the
// cycle it is accepted. A data request shifts one byte into a 16-entry
// lookahead window; once the window is full, or when last_in flushes it, the
// oldest byte leaves on the out channel (out_valid_o, out_stall_i, out_rsp_o),
// replaced by '*' when it begins or lies inside a listed keyword.
// Each leaving byte is judged by one shared compare unit that checks one
// keyword per cycle against the window. A data request keeps in_stall_o high
// while the sequencer steps through the decide, scan and output states for
// each byte it releases; the scan runs over the active keywords, at most
// NumWords, and a match or a running cover ends it early. No new request is
// accepted until the sequencer is back in idle. A flush releases up to 16
// bytes one after another in this way. The user must write the active_words
// register through cfg_we_i and cfg_wdata_i only while the block is idle; the
// block itself does not enforce this.
// Reset empties the window and clears the keyword lengths and active count;
// keyword bytes must be written before use. A stalled output holds its
// result and the sequencer waits until the output register is free.
`default_nettype none

module keyword_mask_filter_core import kmf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire kmf_in_t            in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output kmf_out_t                out_rsp_o,
  input  wire logic               cfg_we_i,
  input  wire logic [ActiveW-1:0] cfg_wdata_i
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDecide = 2'd1;
  localparam logic [1:0] StScan   = 2'd2;
  localparam logic [1:0] StOut    = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [7:0]         byte_q, byte_d;
  logic               en_q, en_d;
  logic               last_q, last_d;
  logic               pushed_q, pushed_d;
  logic [FillW-1:0]   k_q, k_d;
  logic [ActiveW-1:0] w_q, w_d;
  logic [LenW-1:0]    cover_q, cover_d;
  logic               masked_q, masked_d;
  logic [FillW-1:0]   fill_q, fill_d;
  kmf_win_t           win_q, win_d;
  logic [ActiveW-1:0] active_q;
  logic               out_valid_q, out_valid_d;
  kmf_out_t           out_q, out_d;

  logic               in_fire;
  logic               out_free;
  logic [ActiveW-1:0] n_words;
  kmf_tbl_wr_t        tbl_wr;
  logic               hit;
  logic [LenW-1:0]    hit_len;

  assign in_stall_o  = (state_q != StIdle);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign n_words     = (active_q > ActiveW'(NumWords)) ? ActiveW'(NumWords) : active_q;

  always_comb begin
    tbl_wr             = '0;
    tbl_wr.wr_byte     = in_fire && (in_req_i.req_type == ReqWrByte);
    tbl_wr.wr_len      = in_fire && (in_req_i.req_type == ReqSetLen);
    tbl_wr.word_slot   = in_req_i.word_slot;
    tbl_wr.char_slot   = in_req_i.char_slot;
    tbl_wr.byte_value  = in_req_i.byte_value;
    tbl_wr.word_length = in_req_i.word_length;
  end

  kmf_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (tbl_wr),
    .word_idx_i (WordIdxW'(w_d)),
    .win_i      (win_q),
    .fill_i     (fill_q),
    .hit_o      (hit),
    .len_o      (hit_len)
  );

  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    en_d        = en_q;
    last_d      = last_q;
    pushed_d    = pushed_q;
    k_d         = k_q;
    w_d         = w_q;
    cover_d     = cover_q;
    masked_d    = masked_q;
    fill_d      = fill_q;
    win_d       = win_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      StIdle: begin
        if (in_fire && (in_req_i.req_type == ReqData)) begin
          byte_d   = in_req_i.byte_value;
          en_d     = in_req_i.mask_enable;
          last_d   = in_req_i.last_in;
          pushed_d = 1'b0;
          k_d      = '0;
          state_d  = StDecide;
        end
      end
      StDecide: begin
        w_d = '0;
        if (!pushed_q) begin
          if ((fill_q == FillW'(MaxWordLen)) && (k_q == '0)) begin
            state_d = StScan;
          end else begin
            win_d[CharIdxW'(fill_q)].data = byte_q;
            win_d[CharIdxW'(fill_q)].en   = en_q;
            fill_d   = fill_q + 1'b1;
            pushed_d = 1'b1;
          end
        end else if (last_q) begin
          if ((fill_q != '0) && (k_q < FillW'(MaxWordLen))) begin
            state_d = StScan;
          end else begin
            fill_d  = '0;
            cover_d = '0;
            state_d = StIdle;
          end
        end else if ((fill_q == FillW'(MaxWordLen)) && (k_q == '0)) begin
          state_d = StScan;
        end else begin
          state_d = StIdle;
        end
      end
      StScan: begin
        if (cover_q != '0) begin
          masked_d = 1'b1;
          cover_d  = cover_q - 1'b1;
          state_d  = StOut;
        end else if (w_q < n_words) begin
          if (hit) begin
            masked_d = 1'b1;
            cover_d  = hit_len - 1'b1;
            state_d  = StOut;
          end else begin
            w_d = w_q + 1'b1;
          end
        end else begin
          masked_d = 1'b0;
          state_d  = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.out_byte   = masked_q ? MaskChar : win_q[0].data;
          out_d.was_masked = masked_q;
          out_d.out_last   = pushed_q && last_q && (fill_q == FillW'(1));
          for (int i = 0; i < MaxWordLen - 1; i++) begin
            win_d[i] = win_q[i+1];
          end
          fill_d  = fill_q - 1'b1;
          k_d     = k_q + 1'b1;
          state_d = StDecide;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pushed_q    <= 1'b0;
      k_q         <= '0;
      w_q         <= '0;
      cover_q     <= '0;
      fill_q      <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pushed_q    <= pushed_d;
      k_q         <= k_d;
      w_q         <= w_d;
      cover_q     <= cover_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    en_q     <= en_d;
    last_q   <= last_d;
    masked_q <= masked_d;
    win_q    <= win_d;
    out_q    <= out_d;
  end

  // The window never holds more than its depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MaxWordLen))
    else $error("window fill exceeds depth");

  // A byte is only released from a non-empty window.
  a_out_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> (fill_q != '0))
    else $error("release from empty window");

  // A masked result always carries the mask character.
  a_mask_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.was_masked) |-> (out_q.out_byte == MaskChar))
    else $error("masked byte is not the mask character");

  // A pending match never covers more bytes than a keyword can span.
  a_cover_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cover_q < LenW'(MaxWordLen))
    else $error("cover count out of range");

  // After a flush the window is empty when the block is ready again.
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDecide) && pushed_q && last_q && (state_d == StIdle)) |=>
      (fill_q == '0) && (cover_q == '0))
    else $error("window not empty after flush");

endmodule

`default_nettype wire
